// ----- rtl/core/sac_pkg.sv -----
// Shared constants for the swept box collision core.
// No dependencies; imported by the merge stage and the top level.
package sac_pkg;

    localparam logic signed [1:0] NORM_NONE = 2'sb00;
    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;

endpackage

// ----- rtl/core/swept_aabb_collision.sv -----
// Swept 2D box collision test: a fully pipelined core that takes one box pair per cycle and
// returns the hit flag, entry time and surface normal. The pipeline depth is set by the
// restoring dividers, one quotient bit per stage, that run as four lanes (entry and exit
// time on each axis) beside one another; a merge stage holds the output register.
// Each stage stalls only when the stage after it is full, so bubbles close up under backpressure.
// Depends on sac_pkg, sac_axis, sac_div and sac_merge.
module swept_aabb_collision #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // disp_x, disp_y, box_min_x, box_min_y, box_max_x, box_max_y,
    // obst_min_x, obst_min_y, obst_max_x, obst_max_y, zero padded to bytes.
    input  logic [((10*COORD_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // hit, contact time, x normal, y normal, zero padded to bytes.
    output logic [((FRAC_BITS+6+7)/8)*8-1:0]              m_tdata
);
    import sac_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int FW     = FRAC_BITS;
    localparam int NSTG   = FW + 3;
    localparam int OUT_TW = ((FW + 6 + 7) / 8) * 8;

    logic [NSTG-1:0]      vld_reg, vld_next, en;
    logic signed [FW+3:0] x_in, x_out, y_in, y_out;
    logic                 dx_neg, dy_neg, hit;
    logic [FW:0]          contact_t;
    logic signed [1:0]    face_x, face_y;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    sac_axis #(.CW(CW), .FW(FW)) u_axis_x (
        .aclk     (aclk),
        .en       (en[FW+1:0]),
        .v        (s_tdata[0*CW +: CW]),
        .bmin     (s_tdata[2*CW +: CW]),
        .bmax     (s_tdata[4*CW +: CW]),
        .omin     (s_tdata[6*CW +: CW]),
        .omax     (s_tdata[8*CW +: CW]),
        .t_in     (x_in),
        .t_out    (x_out),
        .dist_neg (dx_neg)
    );

    sac_axis #(.CW(CW), .FW(FW)) u_axis_y (
        .aclk     (aclk),
        .en       (en[FW+1:0]),
        .v        (s_tdata[1*CW +: CW]),
        .bmin     (s_tdata[3*CW +: CW]),
        .bmax     (s_tdata[5*CW +: CW]),
        .omin     (s_tdata[7*CW +: CW]),
        .omax     (s_tdata[9*CW +: CW]),
        .t_in     (y_in),
        .t_out    (y_out),
        .dist_neg (dy_neg)
    );

    sac_merge #(.FW(FW)) u_merge (
        .aclk      (aclk),
        .en        (en[NSTG-1]),
        .x_in      (x_in),
        .x_out     (x_out),
        .y_in      (y_in),
        .y_out     (y_out),
        .dx_neg    (dx_neg),
        .dy_neg    (dy_neg),
        .hit       (hit),
        .contact_t (contact_t),
        .face_x    (face_x),
        .face_y    (face_y)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = OUT_TW'({face_y, face_x, contact_t, hit});

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &vld_reg)
        else $error("Input stalled while the pipeline has an empty stage.");

    a_miss_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit) |-> (contact_t == ((FW + 1)'(1) << FW)
                                && face_x == NORM_NONE && face_y == NORM_NONE))
        else $error("A miss must report full frame time and no normal.");

    a_hit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hit) |-> ((face_x != NORM_NONE) != (face_y != NORM_NONE)))
        else $error("A hit must carry a normal on exactly one axis.");

    a_hit_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hit) |-> (contact_t <= ((FW + 1)'(1) << FW)))
        else $error("Hit entry time lies beyond the frame.");

endmodule

// ----- rtl/core/sac_div.sv -----
// Pipelined restoring divider giving one signed Q.FW time per word.
// One quotient bit per stage, saturating at 2.0; no package dependency.
module sac_div #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  logic                 aclk,
    input  logic [FW:0]          en,
    input  logic [CW:0]          ad,
    input  logic [CW-1:0]        av,
    input  logic                 neg,
    input  logic                 zero,
    output logic signed [FW+3:0] t
);

    localparam int TW = FW + 4;

    logic [CW:0]   rem_reg  [FW+1];
    logic [CW:0]   rem_next [FW+1];
    logic [FW:0]   q_reg    [FW+1];
    logic [FW:0]   q_next   [FW+1];
    logic [CW-1:0] av_reg   [FW+1];
    logic [FW:0]   neg_reg;
    logic [FW:0]   sat_reg;
    logic [FW:0]   zero_reg;
    logic          sat_next;
    logic [CW:0]   sh       [FW+1];
    logic [FW:0]   bit_q;
    logic [TW-1:0] mag;

    always_comb begin
        sat_next    = ad >= {av, 1'b0};
        sh[0]       = ad;
        bit_q[0]    = sh[0] >= {1'b0, av};
        rem_next[0] = bit_q[0] ? sh[0] - {1'b0, av} : sh[0];
        q_next[0]   = {{FW{1'b0}}, bit_q[0]};
        for (int k = 1; k <= FW; k++) begin
            sh[k]       = {rem_reg[k-1][CW-1:0], 1'b0};
            bit_q[k]    = sh[k] >= {1'b0, av_reg[k-1]};
            rem_next[k] = bit_q[k] ? sh[k] - {1'b0, av_reg[k-1]} : sh[k];
            q_next[k]   = {q_reg[k-1][FW-1:0], bit_q[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            av_reg[0]   <= av;
            neg_reg[0]  <= neg;
            sat_reg[0]  <= sat_next;
            zero_reg[0] <= zero;
        end
        for (int k = 1; k <= FW; k++) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                av_reg[k]   <= av_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_comb begin
        mag = sat_reg[FW] ? (TW'(1) << (FW + 1)) : TW'(q_reg[FW]);
        if (zero_reg[FW]) begin
            t = neg_reg[FW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
            t = neg_reg[FW] ? -mag : mag;
        end
    end

endmodule

// ----- rtl/core/sac_axis.sv -----
// One axis lane: entry and exit distances, then two dividers for the times.
// Uses sac_div; no package dependency.
module sac_axis #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  logic                 aclk,
    input  logic [FW+1:0]        en,
    input  logic [CW-1:0]        v,
    input  logic [CW-1:0]        bmin,
    input  logic [CW-1:0]        bmax,
    input  logic [CW-1:0]        omin,
    input  logic [CW-1:0]        omax,
    output logic signed [FW+3:0] t_in,
    output logic signed [FW+3:0] t_out,
    output logic                 dist_neg
);

    logic signed [CW:0] a_lo, a_hi, d_in, d_out;
    logic               vpos, vzero;
    logic [CW:0]        ad_in_reg, ad_out_reg;
    logic [CW-1:0]      av_reg;
    logic               neg_in_reg, neg_out_reg, zero_reg;
    logic [FW+1:0]      dneg_reg;

    always_comb begin
        vzero = v == '0;
        vpos  = !v[CW-1] && !vzero;
        a_lo  = $signed({omin[CW-1], omin}) - $signed({bmax[CW-1], bmax});
        a_hi  = $signed({omax[CW-1], omax}) - $signed({bmin[CW-1], bmin});
        d_in  = vpos ? a_lo : a_hi;
        d_out = vpos ? a_hi : a_lo;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ad_in_reg   <= d_in[CW] ? -d_in : d_in;
            ad_out_reg  <= d_out[CW] ? -d_out : d_out;
            av_reg      <= v[CW-1] ? -v : v;
            neg_in_reg  <= vzero | (d_in[CW] ^ v[CW-1]);
            neg_out_reg <= !vzero & (d_out[CW] ^ v[CW-1]);
            zero_reg    <= vzero;
            dneg_reg[0] <= d_in[CW];
        end
        for (int k = 1; k <= FW + 1; k++) begin
            if (en[k]) begin
                dneg_reg[k] <= dneg_reg[k-1];
            end
        end
    end

    sac_div #(.CW(CW), .FW(FW)) u_div_in (
        .aclk (aclk),
        .en   (en[FW+1:1]),
        .ad   (ad_in_reg),
        .av   (av_reg),
        .neg  (neg_in_reg),
        .zero (zero_reg),
        .t    (t_in)
    );

    sac_div #(.CW(CW), .FW(FW)) u_div_out (
        .aclk (aclk),
        .en   (en[FW+1:1]),
        .ad   (ad_out_reg),
        .av   (av_reg),
        .neg  (neg_out_reg),
        .zero (zero_reg),
        .t    (t_out)
    );

    assign dist_neg = dneg_reg[FW+1];

endmodule

// ----- rtl/core/sac_merge.sv -----
// Merge stage: combines both axis lanes into the hit decision and normal.
// Depends on sac_pkg for the normal codes; holds the output register.
module sac_merge #(
    parameter int FW = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [FW+3:0] x_in,
    input  logic signed [FW+3:0] x_out,
    input  logic signed [FW+3:0] y_in,
    input  logic signed [FW+3:0] y_out,
    input  logic                 dx_neg,
    input  logic                 dy_neg,
    output logic                 hit,
    output logic [FW:0]          contact_t,
    output logic signed [1:0]    face_x,
    output logic signed [1:0]    face_y
);
    import sac_pkg::*;

    localparam logic signed [FW+3:0] ONE_T = (FW + 4)'(1) << FW;

    logic signed [FW+3:0] tin, tout;
    logic                 x_last, hit_next;
    logic [FW:0]          entry_reg;
    logic                 hit_reg;
    logic signed [1:0]    nx_reg, ny_reg;

    always_comb begin
        x_last   = x_in > y_in;
        tin      = x_last ? x_in : y_in;
        tout     = (x_out < y_out) ? x_out : y_out;
        hit_next = !(tin > tout || (x_in[FW+3] && y_in[FW+3])
                     || x_in > ONE_T || y_in > ONE_T);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit_next;
            entry_reg <= hit_next ? tin[FW:0] : ONE_T[FW:0];
            nx_reg    <= (hit_next && x_last) ? (dx_neg ? NORM_POS : NORM_NEG) : NORM_NONE;
            ny_reg    <= (hit_next && !x_last) ? (dy_neg ? NORM_POS : NORM_NEG) : NORM_NONE;
        end
    end

    assign hit       = hit_reg;
    assign contact_t = entry_reg;
    assign face_x    = nx_reg;
    assign face_y    = ny_reg;

endmodule

// ----- tb/testbench.sv -----
// Testbench for the swept 2D box collision core: drives box pairs on the input stream,
// predicts hit, entry time and normal for each, and compares every result word in order.
// Depends on sac_pkg and swept_aabb_collision.
`timescale 1ns / 100ps

module testbench;
    import sac_pkg::*;

    localparam int CB = 32;
    localparam int FB = 16;
    localparam int IN_W = ((10 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((FB + 6 + 7) / 8) * 8;
    localparam longint ONE_T = 64'sd1 <<< FB;
    localparam longint SAT_T = 64'sd2 <<< FB;
    localparam longint T_NEG_INF = 64'h8000_0000_0000_0000;
    localparam longint T_POS_INF = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int RAND_ITEMS = 1830;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [1:0] face_y;
        logic signed [1:0] face_x;
        logic [16:0]       contact_t;
        logic              hit;
    } sweep_result_t;

    typedef struct {
        logic signed [CB-1:0] f[10];
        bit                   typed;
        sweep_result_t        res;
    } pair_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    sweep_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_off = 1'b0;
    pair_row_t rows[$];

    swept_aabb_collision #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sweep_div(longint d, longint v);
        longint ad, av, q, r;
        ad = d < 0 ? -d : d;
        av = v < 0 ? -v : v;
        if (ad / av >= 2) begin
            q = SAT_T;
        end else begin
            q = ad / av;
            r = ad % av;
            for (int i = 0; i < FB; i++) begin
                r = r <<< 1;
                q = q <<< 1;
                if (r >= av) begin
                    r -= av;
                    q |= 1;
                end
            end
        end
        return ((d < 0) != (v < 0)) ? -q : q;
    endfunction

    function automatic void axis_sweep(input longint v, mn1, mx1, mn2, mx2,
                                       output longint d_in, t_in, t_out);
        longint d_out;
        d_in = v > 0 ? mn2 - mx1 : mx2 - mn1;
        d_out = v > 0 ? mx2 - mn1 : mn2 - mx1;
        if (v == 0) begin
            t_in = T_NEG_INF;
            t_out = T_POS_INF;
        end else begin
            t_in = sweep_div(d_in, v);
            t_out = sweep_div(d_out, v);
        end
    endfunction

    function automatic sweep_result_t predict_sweep(logic signed [CB-1:0] f[10]);
        longint dx, dy, xin, xout, yin, yout, t_in, t_out;
        sweep_result_t r;
        axis_sweep(f[0], f[2], f[4], f[6], f[8], dx, xin, xout);
        axis_sweep(f[1], f[3], f[5], f[7], f[9], dy, yin, yout);
        t_in = xin > yin ? xin : yin;
        t_out = xout < yout ? xout : yout;
        r.hit = !(t_in > t_out || (xin < 0 && yin < 0) || xin > ONE_T || yin > ONE_T);
        r.face_x = NORM_NONE;
        r.face_y = NORM_NONE;
        if (r.hit) begin
            if (xin > yin) r.face_x = dx < 0 ? NORM_POS : NORM_NEG;
            else r.face_y = dy < 0 ? NORM_POS : NORM_NEG;
        end else begin
            t_in = ONE_T;
        end
        r.contact_t = t_in[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic pair_row_t make_row(longint vx, vy, bx0, by0, bx1, by1,
                                           ox0, oy0, ox1, oy1);
        pair_row_t p;
        p.f[0] = CB'(vx); p.f[1] = CB'(vy); p.f[2] = CB'(bx0); p.f[3] = CB'(by0);
        p.f[4] = CB'(bx1); p.f[5] = CB'(by1); p.f[6] = CB'(ox0); p.f[7] = CB'(oy0);
        p.f[8] = CB'(ox1); p.f[9] = CB'(oy1);
        p.typed = 1'b0;
        return p;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // Mostly near-miss and contact geometry, so the hit and normal paths are exercised.
    function automatic pair_row_t rand_row();
        pair_row_t p;
        int mode;
        longint w, h;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            for (int i = 0; i < 10; i++) p.f[i] = $urandom;
        end else begin
            for (int i = 0; i < 10; i++) p.f[i] = rand_coord(mode < 3 ? 2 : 1);
            w = $urandom_range(0, 32'h0002_0000);
            h = $urandom_range(0, 32'h0002_0000);
            p.f[4] = CB'(p.f[2] + w);
            p.f[5] = CB'(p.f[3] + h);
            p.f[8] = p.f[6] + $urandom_range(0, 32'h0002_0000);
            p.f[9] = p.f[7] + $urandom_range(0, 32'h0002_0000);
            if ($urandom_range(0, 7) == 0) p.f[0] = 0;
            if ($urandom_range(0, 7) == 0) p.f[1] = 0;
        end
        p.typed = 1'b0;
        return p;
    endfunction

    task automatic send_pair(pair_row_t p);
        sweep_result_t exp_res;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        exp_res = p.typed ? p.res : predict_sweep(p.f);
        if (p.typed && p.res != predict_sweep(p.f))
            report_mismatch("table row", p.res, predict_sweep(p.f));
        for (int i = 0; i < 10; i++) s_tdata[i*CB +: CB] <= p.f[i];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(exp_res);
        @(negedge aclk);
    endtask

    initial begin
        pair_row_t p;
        sweep_result_t no_hit;
        no_hit = '{NORM_NONE, NORM_NONE, 17'h10000, 1'b0};

        p = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        p.typed = 1'b1; p.res = no_hit; rows.push_back(p);
        p = make_row(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000,
                     32'sh0001_8000, 0, 32'sh0002_0000, 32'sh0001_0000);
        p.typed = 1'b1; p.res = '{NORM_NONE, NORM_NEG, 17'h8000, 1'b1}; rows.push_back(p);
        p = make_row(-32'sh0001_0000, 0, 32'sh0001_8000, 0, 32'sh0002_0000, 32'sh0001_0000,
                     0, 0, 32'sh0001_0000, 32'sh0001_0000);
        p.typed = 1'b1; p.res = '{NORM_NONE, NORM_POS, 17'h8000, 1'b1}; rows.push_back(p);
        p = make_row(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000,
                     32'sh0005_0000, 0, 32'sh0006_0000, 32'sh0001_0000);
        p.typed = 1'b1; p.res = no_hit; rows.push_back(p);
        p = make_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0004_0000, 0, 0, 32'sh0001_0000, 32'sh0001_0000);
        p.typed = 1'b1; p.res = no_hit; rows.push_back(p);
        rows.push_back(make_row(0, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 32'sh0001_0000,
                                0, 32'sh0001_8000, 32'sh0001_0000, 32'sh0002_0000));
        rows.push_back(make_row(32'sh0001_0000, 32'sh0001_0000, 0, 0, 32'sh0001_0000,
                                32'sh0001_0000, 32'sh0001_8000, 32'sh0001_8000,
                                32'sh0002_0000, 32'sh0002_0000));
        rows.push_back(make_row(1, -1, 0, 0, 1, 1, 3, -3, 4, -2));
        rows.push_back(make_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                32'sh8000_0000));
        rows.push_back(make_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh7FFF_FFFF));
        rows.push_back(make_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        rows.push_back(make_row(32'sh0000_0003, 32'sh0000_0007, 0, 0, 0, 0,
                                1, 2, 5, 9));
        rows.push_back(make_row(32'sh0002_0000, 32'sh0002_0000, 0, 0, 32'sh0001_0000,
                                32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                                32'sh0002_0000, 32'sh0002_0000));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) send_pair(rows[i]);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 300) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            if (n == 600) hold_off = 1'b1;
            if (n == RAND_ITEMS - 200) quiet = 1'b1;
            send_pair(rand_row());
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (FB + 10) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        sweep_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[21:0];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", got, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.contact_t !== want.contact_t)
                    report_mismatch("contact time", got.contact_t, want.contact_t);
                if (got.face_x !== want.face_x)
                    report_mismatch("x normal", got.face_x, want.face_x);
                if (got.face_y !== want.face_y)
                    report_mismatch("y normal", got.face_y, want.face_y);
            end
        end
    end
endmodule
